/* sv/minimum_covering_window_macros.svh */
// assertion macros shared by the minimum covering window rtl
`ifndef MINIMUM_COVERING_WINDOW_MACROS_SVH
`define MINIMUM_COVERING_WINDOW_MACROS_SVH

// condition checked in the same cycle as its trigger
`define MCW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition checked in the cycle after its trigger
`define MCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mcw_pkg.sv */
// shared types and constants of the minimum covering window block
package mcw_pkg;

	// fixed field widths
	localparam int WORD_W    = 16;
	localparam int QWORD_W   = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int QCOUNT_W  = 4;
	localparam int TAG_W     = 4;
	localparam int CNT_W     = 11;
	localparam int MISS_W    = 4;
	localparam int SLOTS_PER_REG = CFG_W / QWORD_W;

	// parameter defaults
	localparam int DEF_MAX_TOKENS = 1024;
	localparam int DEF_MAX_QUERY  = 8;
	localparam int DEF_WORD_BITS  = 16;

	// tag of a word that matches no query slot
	localparam logic [TAG_W-1:0] NO_SLOT = 4'd8;
	// saturation limits
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [MISS_W-1:0] MISS_MAX = '1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUERY_LOW   = 2'd0,
		CFG_QUERY_HIGH  = 2'd1,
		CFG_QUERY_COUNT = 2'd2
	} cfg_reg_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SHRINK,
		ST_FINISH
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic append;
		logic rd_begin;
		logic rd_next;
		logic shrink;
		logic finish;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic shrink_ok;
		logic shrink_more;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage

/* sv/mcw_match.sv */
// query word matcher: slot tag of a word and count of distinct query words
module mcw_match #(
	parameter int MAX_QUERY = mcw_pkg::DEF_MAX_QUERY,
	parameter int WORD_BITS = mcw_pkg::DEF_WORD_BITS
) (
	input  logic [mcw_pkg::CFG_W-1:0]    query_low,
	input  logic [mcw_pkg::CFG_W-1:0]    query_high,
	input  logic [mcw_pkg::QCOUNT_W-1:0] query_count,
	input  logic [WORD_BITS-1:0]         word,
	output logic [mcw_pkg::TAG_W-1:0]    tag,
	output logic [mcw_pkg::MISS_W-1:0]   distinct
);

	logic [WORD_BITS-1:0] qword [MAX_QUERY];
	logic [MAX_QUERY-1:0] used;
	logic [MAX_QUERY-1:0] first;

	// slot words and slots in use
	for (genvar i = 0; i < MAX_QUERY; i++) begin : g_slot
		if (i < mcw_pkg::SLOTS_PER_REG) begin : g_low
			assign qword[i] = query_low[i*mcw_pkg::QWORD_W +: WORD_BITS];
		end else begin : g_high
			assign qword[i] =
				query_high[(i-mcw_pkg::SLOTS_PER_REG)*mcw_pkg::QWORD_W +: WORD_BITS];
		end
		assign used[i] = query_count > mcw_pkg::QCOUNT_W'(i);
	end

	// slot holds the first copy of its word
	always_comb begin
		for (int i = 0; i < MAX_QUERY; i++) begin
			first[i] = used[i];
			for (int j = 0; j < i; j++) begin
				if (qword[j] == qword[i]) begin
					first[i] = 1'b0;
				end
			end
		end
	end

	// lowest matching slot wins
	always_comb begin
		tag = mcw_pkg::NO_SLOT;
		for (int i = MAX_QUERY - 1; i >= 0; i--) begin
			if (used[i] && qword[i] == word) begin
				tag = mcw_pkg::TAG_W'(i);
			end
		end
	end

	// distinct query word count
	always_comb begin
		distinct = '0;
		for (int i = 0; i < MAX_QUERY; i++) begin
			distinct = distinct + mcw_pkg::MISS_W'(first[i]);
		end
	end

endmodule

/* sv/mcw_dpath.sv */
// datapath: configuration, slot counts, tag buffer, window bounds and result register
module mcw_dpath #(
	parameter int MAX_TOKENS = mcw_pkg::DEF_MAX_TOKENS,
	parameter int MAX_QUERY  = mcw_pkg::DEF_MAX_QUERY,
	parameter int WORD_BITS  = mcw_pkg::DEF_WORD_BITS,
	localparam int EW = $clog2(MAX_TOKENS + 1),
	localparam int AW = $clog2(MAX_TOKENS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcw_pkg::CFG_W-1:0]     cfg_data,
	input  logic [mcw_pkg::WORD_W-1:0]    word_id,
	input  logic                          last,
	input  mcw_pkg::ctrl_cmd_t            cmd,
	output mcw_pkg::dp_status_t           status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [EW-1:0]                 best_length,
	output logic [AW-1:0]                 best_start,
	output logic [EW-1:0]                 best_end,
	output logic                          overflow
);

	// configuration
	logic [mcw_pkg::CFG_W-1:0]    qlow_q;
	logic [mcw_pkg::CFG_W-1:0]    qhigh_q;
	logic [mcw_pkg::QCOUNT_W-1:0] qcount_q;

	// sequence state
	logic [mcw_pkg::CNT_W-1:0]  cnt_q [MAX_QUERY];
	logic [mcw_pkg::MISS_W-1:0] miss_q;
	logic [EW-1:0]              begin_q;
	logic [EW-1:0]              end_q;
	logic                       best_found_q;
	logic [EW-1:0]              best_len_q;
	logic [AW-1:0]              best_start_q;
	logic [EW-1:0]              best_end_q;
	logic                       ovf_q;
	logic                       active_q;
	logic                       last_q;
	logic                       appended_q;

	// tag buffer
	logic [mcw_pkg::TAG_W-1:0] tag_mem [MAX_TOKENS];
	logic [mcw_pkg::TAG_W-1:0] rd_tag_q;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;

	// result register
	logic          out_valid_q;
	logic          found_q;
	logic [EW-1:0] len_out_q;
	logic [AW-1:0] start_out_q;
	logic [EW-1:0] end_out_q;
	logic          ovf_out_q;

	// matcher outputs
	logic [mcw_pkg::TAG_W-1:0]  tag;
	logic [mcw_pkg::MISS_W-1:0] distinct;

	// append path
	logic                       fresh;
	logic                       room;
	logic [mcw_pkg::CNT_W-1:0]  base_cnt [MAX_QUERY];
	logic [mcw_pkg::CNT_W-1:0]  app_cnt [MAX_QUERY];
	logic [mcw_pkg::MISS_W-1:0] base_miss;
	logic [mcw_pkg::MISS_W-1:0] app_miss;
	logic                       any_new;

	// shrink path
	logic [EW-1:0]              win_len;
	logic                       better;
	logic [mcw_pkg::CNT_W-1:0]  shr_cnt [MAX_QUERY];
	logic [mcw_pkg::MISS_W-1:0] shr_miss;
	logic                       emptied;
	logic [EW-1:0]              begin_nx;

	mcw_match #(
		.MAX_QUERY (MAX_QUERY),
		.WORD_BITS (WORD_BITS)
	) u_match (
		.query_low   (qlow_q),
		.query_high  (qhigh_q),
		.query_count (qcount_q),
		.word        (word_id[WORD_BITS-1:0]),
		.tag         (tag),
		.distinct    (distinct)
	);

	// append of one word: counts restart on the first word of a sequence
	assign fresh     = end_q == '0;
	assign room      = end_q < EW'(MAX_TOKENS);
	assign base_miss = fresh ? distinct : miss_q;

	always_comb begin
		any_new = 1'b0;
		for (int i = 0; i < MAX_QUERY; i++) begin
			base_cnt[i] = fresh ? '0 : cnt_q[i];
			app_cnt[i]  = base_cnt[i];
			if (tag == mcw_pkg::TAG_W'(i)) begin
				if (base_cnt[i] == '0) begin
					any_new = 1'b1;
				end
				if (base_cnt[i] != mcw_pkg::CNT_MAX) begin
					app_cnt[i] = base_cnt[i] + mcw_pkg::CNT_W'(1);
				end
			end
		end
		app_miss = (any_new && base_miss != '0) ? base_miss - mcw_pkg::MISS_W'(1) : base_miss;
	end

	// removal of the front word of the window
	assign win_len  = end_q - begin_q;
	assign better   = !best_found_q || win_len < best_len_q;
	assign begin_nx = begin_q + EW'(1);

	always_comb begin
		emptied = 1'b0;
		for (int i = 0; i < MAX_QUERY; i++) begin
			shr_cnt[i] = cnt_q[i];
			if (rd_tag_q == mcw_pkg::TAG_W'(i) && cnt_q[i] != '0) begin
				shr_cnt[i] = cnt_q[i] - mcw_pkg::CNT_W'(1);
				if (cnt_q[i] == mcw_pkg::CNT_W'(1)) begin
					emptied = 1'b1;
				end
			end
		end
		shr_miss = (emptied && miss_q != mcw_pkg::MISS_MAX) ?
			miss_q + mcw_pkg::MISS_W'(1) : miss_q;
	end

	// status toward the controller
	assign status.shrink_ok   = appended_q && active_q && miss_q == '0 && begin_q < end_q;
	assign status.shrink_more = active_q && shr_miss == '0 && begin_nx < end_q;
	assign status.last        = last_q;
	assign status.out_free    = !out_valid_q || !out_stall;

	// configuration and sequence control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlow_q       <= '0;
			qhigh_q      <= '0;
			qcount_q     <= '0;
			for (int i = 0; i < MAX_QUERY; i++) begin
				cnt_q[i] <= '0;
			end
			miss_q       <= '0;
			begin_q      <= '0;
			end_q        <= '0;
			best_found_q <= 1'b0;
			ovf_q        <= 1'b0;
			active_q     <= 1'b0;
			last_q       <= 1'b0;
			appended_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (mcw_pkg::cfg_reg_t'(cfg_index))
					mcw_pkg::CFG_QUERY_LOW:   qlow_q   <= cfg_data;
					mcw_pkg::CFG_QUERY_HIGH:  qhigh_q  <= cfg_data;
					mcw_pkg::CFG_QUERY_COUNT: qcount_q <= cfg_data[mcw_pkg::QCOUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.append) begin
				last_q   <= last;
				active_q <= distinct != '0;
				if (room) begin
					end_q      <= end_q + EW'(1);
					cnt_q      <= app_cnt;
					miss_q     <= app_miss;
					appended_q <= 1'b1;
				end else begin
					ovf_q      <= 1'b1;
					appended_q <= 1'b0;
				end
			end
			if (cmd.shrink) begin
				if (better) begin
					best_found_q <= 1'b1;
				end
				cnt_q   <= shr_cnt;
				miss_q  <= shr_miss;
				begin_q <= begin_nx;
			end
			if (cmd.finish) begin
				for (int i = 0; i < MAX_QUERY; i++) begin
					cnt_q[i] <= '0;
				end
				miss_q       <= distinct;
				begin_q      <= '0;
				end_q        <= '0;
				best_found_q <= 1'b0;
				ovf_q        <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// best window and result word
	always_ff @(posedge clk) begin
		if (cmd.shrink && better) begin
			best_len_q   <= win_len;
			best_start_q <= begin_q[AW-1:0];
			best_end_q   <= end_q;
		end
		if (cmd.finish) begin
			found_q     <= best_found_q;
			len_out_q   <= best_found_q ? best_len_q : '0;
			start_out_q <= best_found_q ? best_start_q : '0;
			end_out_q   <= best_found_q ? best_end_q : '0;
			ovf_out_q   <= ovf_q;
		end
	end

	// tag buffer: written at the window end, read at the window front
	assign rd_en   = cmd.rd_begin || cmd.rd_next;
	assign rd_addr = cmd.rd_next ? begin_nx[AW-1:0] : begin_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.append && room) begin
			tag_mem[end_q[AW-1:0]] <= tag;
		end
		if (rd_en) begin
			rd_tag_q <= tag_mem[rd_addr];
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign best_length = len_out_q;
	assign best_start  = start_out_q;
	assign best_end    = end_out_q;
	assign overflow    = ovf_out_q;

endmodule

/* sv/mcw_ctrl.sv */
// controller state machine: append, window shrink loop and result hand-off
module mcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mcw_pkg::dp_status_t status,
	output mcw_pkg::ctrl_cmd_t  cmd
);

	mcw_pkg::ctrl_state_t state_q;
	mcw_pkg::ctrl_state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mcw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = mcw_pkg::ST_CHECK;
				end
			end
			mcw_pkg::ST_CHECK: begin
				if (status.shrink_ok) begin
					state_nx = mcw_pkg::ST_SHRINK;
				end else if (status.last) begin
					state_nx = mcw_pkg::ST_FINISH;
				end else begin
					state_nx = mcw_pkg::ST_IDLE;
				end
			end
			mcw_pkg::ST_SHRINK: begin
				if (status.shrink_more) begin
					state_nx = mcw_pkg::ST_SHRINK;
				end else if (status.last) begin
					state_nx = mcw_pkg::ST_FINISH;
				end else begin
					state_nx = mcw_pkg::ST_IDLE;
				end
			end
			mcw_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_nx = mcw_pkg::ST_IDLE;
				end
			end
			default: state_nx = mcw_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			mcw_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.append = in_valid;
			end
			mcw_pkg::ST_CHECK: begin
				cmd.rd_begin = status.shrink_ok;
			end
			mcw_pkg::ST_SHRINK: begin
				cmd.shrink  = 1'b1;
				cmd.rd_next = status.shrink_more;
			end
			mcw_pkg::ST_FINISH: begin
				cmd.finish = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

/* sv/minimum_covering_window.sv */
// top level of the minimum covering window block
//
// Words arrive on the input channel (word_id, last) under in_valid / in_stall.
// For every sequence of words the block finds the shortest run that holds each
// configured query word at least once; on the word flagged last it sends one
// result word (found, best_length, best_start, best_end, overflow) on the output
// channel under out_valid / out_stall and starts a new sequence.
// Query words and their count must be written through cfg_we / cfg_index /
// cfg_data while no sequence word is in work; the block does not enforce it.
// A word is accepted and checked for coverage; then the front removal loop
// pushes words off the front of the window, one tag buffer read per cycle.
// Each word leaves the window at most once. For the last word the result is
// loaded after the removals, once the output register is free.
// The result sits in an output register; the next word is taken while it waits.
// A second result waits in the controller until out_stall drops.
// Reset clears configuration, counts, bounds and flags; the tag buffer needs
// no clearing since only entries written in the current sequence are read.
// Words beyond MAX_TOKENS in one sequence are dropped and raise overflow.
`include "minimum_covering_window_macros.svh"

module minimum_covering_window #(
	parameter int MAX_TOKENS = mcw_pkg::DEF_MAX_TOKENS,
	parameter int MAX_QUERY  = mcw_pkg::DEF_MAX_QUERY,
	parameter int WORD_BITS  = mcw_pkg::DEF_WORD_BITS,
	localparam int EW = $clog2(MAX_TOKENS + 1),
	localparam int AW = $clog2(MAX_TOKENS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcw_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mcw_pkg::WORD_W-1:0]    word_id,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [EW-1:0]                 best_length,
	output logic [AW-1:0]                 best_start,
	output logic [EW-1:0]                 best_end,
	output logic                          overflow
);

	mcw_pkg::ctrl_cmd_t  cmd;
	mcw_pkg::dp_status_t status;

	// terms used by the checks
	logic in_accept;
	logic window_clear;
	logic window_span_ok;

	mcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mcw_dpath #(
		.MAX_TOKENS (MAX_TOKENS),
		.MAX_QUERY  (MAX_QUERY),
		.WORD_BITS  (WORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.word_id     (word_id),
		.last        (last),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.best_length (best_length),
		.best_start  (best_start),
		.best_end    (best_end),
		.overflow    (overflow)
	);

	assign in_accept      = in_valid && !in_stall;
	assign window_clear   = best_length == '0 && best_start == '0 && best_end == '0;
	assign window_span_ok = best_length != '0 && best_end == EW'(best_start) + best_length;

	// checks on the controller and the result word
	`MCW_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall, "word taken while busy")
	`MCW_ASSERT_SAME(a_finish_on_last, cmd.finish, status.last, "result without last word")
	`MCW_ASSERT_SAME(a_zero_when_missing, out_valid && !found, window_clear, "window set, not found")
	`MCW_ASSERT_SAME(a_window_span, out_valid && found, window_span_ok, "window bounds disagree")

endmodule

/* bench/minimum_covering_window_checker.sv */
`timescale 1ns / 100ps
// checker: watches the channels, predicts each result word and compares it
module minimum_covering_window_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcw_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [mcw_pkg::WORD_W-1:0]    word_id,
	input  logic                          last,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          found,
	input  logic [10:0]                   best_length,
	input  logic [9:0]                    best_start,
	input  logic [10:0]                   best_end,
	input  logic                          overflow,
	output int                            errors,
	output int                            pending
);

	localparam int BUF_DEPTH = mcw_pkg::DEF_MAX_TOKENS;

	typedef struct packed {
		logic        found;
		logic [10:0] len;
		logic [9:0]  start_idx;
		logic [10:0] end_idx;
		logic        overflow;
	} cover_result_t;

	// shadow of the query registers
	logic [mcw_pkg::CFG_W-1:0]    query_low;
	logic [mcw_pkg::CFG_W-1:0]    query_high;
	logic [mcw_pkg::QCOUNT_W-1:0] query_cnt;

	// shadow of the sequence state
	logic [mcw_pkg::CNT_W-1:0] slot_hits [8];
	int                        missing;
	logic [mcw_pkg::TAG_W-1:0] tag_buf [BUF_DEPTH];
	int                        head;
	int                        tail;
	int                        best_len;
	int                        best_first;
	int                        best_past;
	logic                      dropped;

	cover_result_t cover_q[$];

	function automatic int slots_in_use();
		return (query_cnt > 8) ? 8 : int'(query_cnt);
	endfunction

	function automatic logic [mcw_pkg::QWORD_W-1:0] query_at(int s);
		logic [mcw_pkg::CFG_W-1:0] r;
		r = (s < mcw_pkg::SLOTS_PER_REG) ? query_low : query_high;
		return r[(s % mcw_pkg::SLOTS_PER_REG) * mcw_pkg::QWORD_W +: mcw_pkg::QWORD_W];
	endfunction

	// lowest slot in use holding this word
	function automatic logic [mcw_pkg::TAG_W-1:0] slot_for(logic [mcw_pkg::WORD_W-1:0] w);
		for (int i = 0; i < slots_in_use(); i++)
			if (query_at(i) == w)
				return mcw_pkg::TAG_W'(i);
		return mcw_pkg::NO_SLOT;
	endfunction

	function automatic int distinct_count();
		int d;
		d = 0;
		for (int i = 0; i < slots_in_use(); i++)
			if (slot_for(query_at(i)) == mcw_pkg::TAG_W'(i))
				d++;
		return d;
	endfunction

	function void start_sequence();
		foreach (slot_hits[i])
			slot_hits[i] = '0;
		missing    = distinct_count();
		head       = 0;
		tail       = 0;
		best_len   = BUF_DEPTH + 1;
		best_first = 0;
		best_past  = 0;
		dropped    = 1'b0;
	endfunction

	// append one word, shrink the window, and queue a result on the last word
	function void track_word(logic [mcw_pkg::WORD_W-1:0] w, logic is_last);
		logic [mcw_pkg::TAG_W-1:0] tag;
		logic [mcw_pkg::TAG_W-1:0] old;
		bit                        active;
		cover_result_t             r;
		if (tail == 0) begin
			foreach (slot_hits[i])
				slot_hits[i] = '0;
			missing = distinct_count();
		end
		active = distinct_count() > 0;
		if (tail >= BUF_DEPTH) begin
			dropped = 1'b1;
		end else begin
			tag = slot_for(w);
			tag_buf[tail] = tag;
			tail++;
			if (tag != mcw_pkg::NO_SLOT) begin
				if (slot_hits[tag] == 0 && missing > 0)
					missing--;
				if (slot_hits[tag] != mcw_pkg::CNT_MAX)
					slot_hits[tag]++;
			end
			while (active && missing == 0 && head < tail) begin
				if (tail - head < best_len) begin
					best_len   = tail - head;
					best_first = head;
					best_past  = tail;
				end
				old = tag_buf[head % BUF_DEPTH];
				if (old != mcw_pkg::NO_SLOT && slot_hits[old] > 0) begin
					slot_hits[old]--;
					if (slot_hits[old] == 0 && missing < 15)
						missing++;
				end
				head++;
			end
		end
		if (is_last) begin
			r = '0;
			if (best_len <= BUF_DEPTH) begin
				r.found     = 1'b1;
				r.len       = best_len[10:0];
				r.start_idx = best_first[9:0];
				r.end_idx   = best_past[10:0];
			end
			r.overflow = dropped;
			cover_q.push_back(r);
			start_sequence();
		end
	endfunction

	function void compare_field(string field, logic [10:0] want, logic [10:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_result();
		cover_result_t want;
		if (cover_q.size() == 0) begin
			$display("%0t ns: stray result, expected none, actual %0d/%0d/%0d/%0d/%0d",
				$time, found, best_length, best_start, best_end, overflow);
			errors++;
			return;
		end
		want = cover_q.pop_front();
		compare_field("found", 11'(want.found), 11'(found));
		compare_field("best_length", want.len, best_length);
		compare_field("best_start", 11'(want.start_idx), 11'(best_start));
		compare_field("best_end", want.end_idx, best_end);
		compare_field("overflow", 11'(want.overflow), 11'(overflow));
	endfunction

	// follow config writes, accepted words and accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_low  = '0;
			query_high = '0;
			query_cnt  = '0;
			start_sequence();
			cover_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (in_valid && !in_stall)
				track_word(word_id, last);
			if (cfg_we) begin
				case (cfg_index)
					mcw_pkg::CFG_QUERY_LOW:   query_low  = cfg_data;
					mcw_pkg::CFG_QUERY_HIGH:  query_high = cfg_data;
					mcw_pkg::CFG_QUERY_COUNT: query_cnt  = cfg_data[mcw_pkg::QCOUNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_result();
			pending = cover_q.size();
		end
	end

endmodule

/* bench/minimum_covering_window_tb.sv */
`timescale 1ns / 100ps
// testbench top: stimulus, idling phases and verdict for the minimum covering window
module minimum_covering_window_tb;

	localparam int SETTLE_CYCLES = 3 * mcw_pkg::DEF_MAX_TOKENS + 16;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 750 / PHASES;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [mcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mcw_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic [mcw_pkg::WORD_W-1:0]    word_id   = '0;
	logic                          last      = 1'b0;
	logic                          out_stall = 1'b0;
	wire                           in_stall;
	wire                           out_valid;
	wire                           found;
	wire  [10:0]                   best_length;
	wire  [9:0]                    best_start;
	wire  [10:0]                   best_end;
	wire                           overflow;
	int                            errors;
	int                            pending;

	int           send_idle_pct = 0;
	int           stall_pct     = 0;
	logic [127:0] cur_words     = '0;

	minimum_covering_window u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.word_id     (word_id),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.best_length (best_length),
		.best_start  (best_start),
		.best_end    (best_end),
		.overflow    (overflow)
	);

	minimum_covering_window_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.word_id     (word_id),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.best_length (best_length),
		.best_start  (best_start),
		.best_end    (best_end),
		.overflow    (overflow),
		.errors      (errors),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	// receiver stall
	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [mcw_pkg::WORD_W-1:0] pool_word();
		case ($urandom_range(0, 3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			default: return 16'h0001;
		endcase
	endfunction

	// mostly query words, some edge values, some noise
	function automatic logic [mcw_pkg::WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return cur_words[16 * $urandom_range(0, 7) +: 16];
		if (r < 70)
			return pool_word();
		return 16'($urandom);
	endfunction

	// random word that matches no query slot
	function automatic logic [mcw_pkg::WORD_W-1:0] noise_word();
		logic [mcw_pkg::WORD_W-1:0] w;
		bit                         clash;
		w = 16'($urandom);
		do begin
			clash = 1'b0;
			for (int s = 0; s < 8; s++)
				if (cur_words[s * 16 +: 16] == w)
					clash = 1'b1;
			if (clash)
				w++;
		end while (clash);
		return w;
	endfunction

	// drop valid and wait until every result has arrived and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_query(input logic [127:0] words,
		input logic [mcw_pkg::QCOUNT_W-1:0] cnt);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= mcw_pkg::CFG_QUERY_LOW;
		cfg_data  <= words[63:0];
		@(posedge clk);
		cfg_index <= mcw_pkg::CFG_QUERY_HIGH;
		cfg_data  <= words[127:64];
		@(posedge clk);
		cfg_index <= mcw_pkg::CFG_QUERY_COUNT;
		cfg_data  <= mcw_pkg::CFG_W'(cnt);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_words = words;
	endtask

	task automatic send_word(input logic [mcw_pkg::WORD_W-1:0] w, input logic is_last);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		word_id  <= w;
		last     <= is_last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_sequence(input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_word(pick_word(), close && i == len - 1);
	endtask

	initial begin
		logic [127:0] words;
		logic [15:0]  qw;
		int           sent;
		int           len;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no query words after reset: never covered
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b1);

		// all eight slots with duplicates and extreme ids
		load_query({16'h8000, 16'h0001, 16'hBEEF, 16'hFFFF,
			16'h1234, 16'h0000, 16'hFFFF, 16'h0000}, 4'd8);
		send_word(16'h1234, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'hBEEF, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h1234, 1'b1);
		send_word(16'h0000, 1'b1);

		// count above eight acts as eight
		load_query(cur_words, 4'd15);
		send_word(16'h8000, 1'b0);
		send_word(16'hBEEF, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h1234, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b1);

		// single query word: one-word window, ties go to the earliest
		load_query(128'h0, 4'd1);
		send_word(16'h0000, 1'b1);
		send_word(16'h0005, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h0000, 1'b1);

		// window spanning the whole buffer, closed in its final entry, then words past it
		load_query({96'h0, 16'h2222, 16'h1111}, 4'd2);
		send_word(16'h1111, 1'b0);
		for (int i = 1; i < mcw_pkg::DEF_MAX_TOKENS - 1; i++)
			send_word(noise_word(), 1'b0);
		send_word(16'h2222, 1'b0);
		for (int i = 0; i < 6; i++)
			send_word((i % 2 == 0) ? 16'h2222 : noise_word(), i == 5);

		// random phases with varying idling and query sets
		for (int p = 0; p < PHASES; p++) begin
			words = '0;
			for (int s = 0; s < 8; s++) begin
				case ($urandom_range(0, 4))
					0:       qw = pool_word();
					1:       qw = (s > 0) ? words[16 * $urandom_range(0, s - 1) +: 16]
						: 16'($urandom);
					default: qw = 16'($urandom);
				endcase
				words[s * 16 +: 16] = qw;
			end
			if (p == 0)
				load_query(words, 4'd8);
			else if (p == 2)
				load_query(words, 4'd0);
			else
				load_query(words, 4'($urandom_range(1, 8)));

			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 80;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 80;
				end
				default: begin
					send_idle_pct = 20;
					stall_pct     = 20;
				end
			endcase

			sent = 0;
			while (sent < PHASE_WORDS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
				send_sequence(len, 1'b1);
				sent += len;
			end
			// sometimes leave a sequence open across the next query change
			if (p < PHASES - 1 && $urandom_range(0, 2) == 0)
				send_sequence($urandom_range(1, 5), 1'b0);
		end

		wait_idle();
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* minimum_covering_window.f */
+incdir+sv
sv/mcw_pkg.sv
sv/mcw_match.sv
sv/mcw_dpath.sv
sv/mcw_ctrl.sv
sv/minimum_covering_window.sv
bench/minimum_covering_window_checker.sv
bench/minimum_covering_window_tb.sv
